### src/sadc_pkg.sv
`timescale 1ns / 1ps
// Package for the serial ADC read sequencer.
// Holds the sequence constants, the half-period reset value and the link pin struct.
// No dependencies.
package sadc_pkg;

    // Default word length of the converter.
    localparam int DEF_DATA_BITS = 8;

    // Width of the reported conversion value.
    localparam int VALUE_W = 8;

    // Half periods spent in the command and settling phase.
    localparam int CMD_SEGS = 9;

    // Command half periods that carry the odd bit and the select bit.
    localparam int POS_ODD_LO = 4;
    localparam int POS_ODD_HI = 5;
    localparam int POS_SEL    = 6;

    // Half-period length after reset, in ticks.
    localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;

    // Levels on the three-wire link, plus the end-of-sequence pulse.
    typedef struct packed {
        logic chip_select;
        logic serial_clock;
        logic data_out;
        logic data_drive;
        logic done;
    } t_link_pins;

endpackage

### src/sadc_step.sv
`timescale 1ns / 1ps
// Next-state and pin logic of the serial ADC read sequencer for one timebase tick.
// Purely combinational; uses sadc_pkg.
module sadc_step
    import sadc_pkg::*;
#(
    parameter int DATA_BITS = DEF_DATA_BITS,
    parameter int POS_W     = $clog2(CMD_SEGS + 4 * DATA_BITS)
) (
    input  logic [7:0]           i_half_period,
    input  logic                 i_start_req,
    input  logic [1:0]           i_channel,
    input  logic                 i_data_in,
    input  logic                 i_busy,
    input  logic [POS_W-1:0]     i_pos,
    input  logic [7:0]           i_tick,
    input  logic [1:0]           i_mux,
    input  logic [DATA_BITS-1:0] i_msb_word,
    input  logic [DATA_BITS-1:0] i_lsb_word,
    input  logic [VALUE_W-1:0]   i_result,
    input  logic                 i_mismatch,
    output logic                 o_busy_nxt,
    output logic [POS_W-1:0]     o_pos_nxt,
    output logic [7:0]           o_tick_nxt,
    output logic [1:0]           o_mux_nxt,
    output logic [DATA_BITS-1:0] o_msb_word_nxt,
    output logic [DATA_BITS-1:0] o_lsb_word_nxt,
    output logic [VALUE_W-1:0]   o_result_nxt,
    output logic                 o_mismatch_nxt,
    output t_link_pins           o_pins
);

    localparam int TOTAL_SEGS = CMD_SEGS + 4 * DATA_BITS;
    localparam int K_W        = POS_W - 1;

    localparam logic [POS_W-1:0] CMD_END   = POS_W'(CMD_SEGS);
    localparam logic [POS_W-1:0] LAST_POS  = POS_W'(TOTAL_SEGS - 1);
    localparam logic [POS_W-1:0] ODD_LO    = POS_W'(POS_ODD_LO);
    localparam logic [POS_W-1:0] ODD_HI    = POS_W'(POS_ODD_HI);
    localparam logic [POS_W-1:0] SEL_POS   = POS_W'(POS_SEL);
    localparam logic [K_W-1:0]   K_DB      = K_W'(DATA_BITS);
    localparam logic [K_W-1:0]   K_LAST    = K_W'(DATA_BITS - 1);

    logic [7:0]                   hp;
    logic                         half_end;
    logic [POS_W-1:0]             q;
    logic [K_W-1:0]               k;
    logic [K_W-1:0]               j;
    logic                         sample_now;
    logic [DATA_BITS-1:0]         msb_s;
    logic [DATA_BITS-1:0]         lsb_s;
    logic [DATA_BITS+VALUE_W-1:0] msb_wide;
    logic                         same;
    logic [POS_W-1:0]             qn;
    logic                         done_nxt;

    // A zero half period behaves as one tick.
    assign hp       = (i_half_period == 8'd0) ? 8'd1 : i_half_period;
    assign half_end = ({1'b0, i_tick} + 9'd1) >= {1'b0, hp};

    // Read-phase bit index: odd read half periods end with the clock low.
    assign q          = i_pos - CMD_END;
    assign k          = q[POS_W-1:1];
    assign j          = k - K_LAST;
    assign sample_now = (i_pos >= CMD_END) && q[0];

    // Shift the sample into the MSB-first word, into the LSB-first word, or both.
    always_comb begin
        msb_s = i_msb_word;
        lsb_s = i_lsb_word;
        if (sample_now) begin
            if (k < K_DB) begin
                msb_s = {i_msb_word[DATA_BITS-2:0], i_data_in};
                if (k == K_LAST) begin
                    lsb_s[0] = i_lsb_word[0] | i_data_in;
                end
            end else begin
                for (int b = 0; b < DATA_BITS; b++) begin
                    if (j == K_W'(b)) begin
                        lsb_s[b] = i_lsb_word[b] | i_data_in;
                    end
                end
            end
        end
    end

    assign same     = (msb_s == lsb_s);
    assign msb_wide = {{VALUE_W{1'b0}}, msb_s};

    // Sequence control: start when idle, otherwise step once per half period.
    always_comb begin
        o_busy_nxt     = i_busy;
        o_pos_nxt      = i_pos;
        o_tick_nxt     = i_tick;
        o_mux_nxt      = i_mux;
        o_msb_word_nxt = i_msb_word;
        o_lsb_word_nxt = i_lsb_word;
        o_result_nxt   = i_result;
        o_mismatch_nxt = i_mismatch;
        done_nxt       = 1'b0;
        if (!i_busy) begin
            if (i_start_req) begin
                o_busy_nxt     = 1'b1;
                o_pos_nxt      = '0;
                o_tick_nxt     = 8'd0;
                o_mux_nxt      = {(i_channel > 2'd1), i_channel[0]};
                o_msb_word_nxt = '0;
                o_lsb_word_nxt = '0;
            end
        end else if (half_end) begin
            o_tick_nxt     = 8'd0;
            o_msb_word_nxt = msb_s;
            o_lsb_word_nxt = lsb_s;
            if (i_pos >= LAST_POS) begin
                o_result_nxt   = same ? msb_wide[VALUE_W-1:0] : '0;
                o_mismatch_nxt = !same;
                o_busy_nxt     = 1'b0;
                o_pos_nxt      = '0;
                done_nxt       = 1'b1;
            end else begin
                o_pos_nxt = i_pos + POS_W'(1);
            end
        end else begin
            o_tick_nxt = i_tick + 8'd1;
        end
    end

    assign qn = o_pos_nxt - CMD_END;

    // Link levels follow the state after this tick.
    always_comb begin
        o_pins.chip_select  = 1'b1;
        o_pins.serial_clock = 1'b0;
        o_pins.data_out     = 1'b1;
        o_pins.data_drive   = 1'b1;
        o_pins.done         = done_nxt;
        if (o_busy_nxt) begin
            o_pins.chip_select = 1'b0;
            if (o_pos_nxt < CMD_END) begin
                o_pins.serial_clock = o_pos_nxt[0];
                if (o_pos_nxt == ODD_LO || o_pos_nxt == ODD_HI) begin
                    o_pins.data_out = o_mux_nxt[0];
                end else if (o_pos_nxt == SEL_POS) begin
                    o_pins.data_out = o_mux_nxt[1];
                end
            end else begin
                o_pins.serial_clock = !qn[0];
                o_pins.data_drive   = 1'b0;
                o_pins.data_out     = 1'b0;
            end
        end
    end

endmodule

### src/serial_adc_read_sequencer_core.sv
`timescale 1ns / 1ps
// Top level of the serial ADC read sequencer: state registers, result register and handshakes.
// Depends on sadc_pkg and sadc_step.
//
// Usage: each input transaction is one timebase tick carrying i_start_req, i_channel and the
// sampled data line level i_data_in. Every input transaction yields exactly one output
// transaction with the link levels (chip select, serial clock, data out, drive enable), the
// busy flag, a one-transaction done pulse, the last value and the mismatch flag.
// A conversion runs 9 + 4 * DATA_BITS half periods of i_cfg_wr_data ticks each (zero acts as
// one); the value is taken as the MSB-first word when it agrees with the LSB-first word.
// The output transaction for a tick is valid the cycle after the tick is accepted. Throughput
// is one tick per cycle, set by the single result register; a new tick is accepted whenever
// the result register is empty or is being taken in the same cycle.
// When the receiver stalls, the result register holds and the input is not accepted.
// The half-period register is written whenever i_cfg_wr_en is high.
// Reset (synchronous, active low) returns the sequencer to idle, clears the words, the value
// and the mismatch flag, sets the half period to 2 ticks and empties the result register.
module serial_adc_read_sequencer_core
    import sadc_pkg::*;
#(
    parameter int DATA_BITS = DEF_DATA_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [7:0]         i_cfg_wr_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_start_req,
    input  logic [1:0]         i_channel,
    input  logic               i_data_in,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_chip_select,
    output logic               o_serial_clock,
    output logic               o_data_out,
    output logic               o_data_drive,
    output logic               o_busy_res,
    output logic               o_done_res,
    output logic [VALUE_W-1:0] o_value,
    output logic               o_mismatch
);

    localparam int POS_W = $clog2(CMD_SEGS + 4 * DATA_BITS);

    logic [7:0]           r_half_period;
    logic                 r_busy,     n_busy;
    logic [POS_W-1:0]     r_pos,      n_pos;
    logic [7:0]           r_tick,     n_tick;
    logic [1:0]           r_mux,      n_mux;
    logic [DATA_BITS-1:0] r_msb_word, n_msb_word;
    logic [DATA_BITS-1:0] r_lsb_word, n_lsb_word;
    logic [VALUE_W-1:0]   r_result,   n_result;
    logic                 r_mismatch, n_mismatch;
    t_link_pins           r_pins,     n_pins;
    logic                 r_out_valid;
    logic                 accept;

    // A tick is taken when the result register is free or drains this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    sadc_step #(
        .DATA_BITS (DATA_BITS),
        .POS_W     (POS_W)
    ) u_step (
        .i_half_period  (r_half_period),
        .i_start_req    (i_start_req),
        .i_channel      (i_channel),
        .i_data_in      (i_data_in),
        .i_busy         (r_busy),
        .i_pos          (r_pos),
        .i_tick         (r_tick),
        .i_mux          (r_mux),
        .i_msb_word     (r_msb_word),
        .i_lsb_word     (r_lsb_word),
        .i_result       (r_result),
        .i_mismatch     (r_mismatch),
        .o_busy_nxt     (n_busy),
        .o_pos_nxt      (n_pos),
        .o_tick_nxt     (n_tick),
        .o_mux_nxt      (n_mux),
        .o_msb_word_nxt (n_msb_word),
        .o_lsb_word_nxt (n_lsb_word),
        .o_result_nxt   (n_result),
        .o_mismatch_nxt (n_mismatch),
        .o_pins         (n_pins)
    );

    // Half-period configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_half_period <= i_cfg_wr_data;
        end
    end

    // Sequencer state advances once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_pos      <= '0;
            r_tick     <= 8'd0;
            r_mux      <= 2'd0;
            r_msb_word <= '0;
            r_lsb_word <= '0;
            r_result   <= '0;
            r_mismatch <= 1'b0;
        end else if (accept) begin
            r_busy     <= n_busy;
            r_pos      <= n_pos;
            r_tick     <= n_tick;
            r_mux      <= n_mux;
            r_msb_word <= n_msb_word;
            r_lsb_word <= n_lsb_word;
            r_result   <= n_result;
            r_mismatch <= n_mismatch;
        end
    end

    // Result register for the link levels and the done pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pins <= n_pins;
        end
    end

    // Busy, value and mismatch change only on accepted ticks, so the state drives them.
    assign o_out_valid    = r_out_valid;
    assign o_chip_select  = r_pins.chip_select;
    assign o_serial_clock = r_pins.serial_clock;
    assign o_data_out     = r_pins.data_out;
    assign o_data_drive   = r_pins.data_drive;
    assign o_done_res     = r_pins.done;
    assign o_busy_res     = r_busy;
    assign o_value        = r_result;
    assign o_mismatch     = r_mismatch;

endmodule
